### hdl/llwr_pkg.sv
// Shared types, codes and widths for the link loss watchdog.
`timescale 1ns / 1ps
`default_nettype none

package llwr_pkg;

    localparam int TIME_BITS   = 48;
    localparam int LIMIT_BITS  = 32;
    localparam int COUNT_BITS  = 8;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;

    // action codes
    localparam logic [1:0] ACT_STEP    = 2'd0;
    localparam logic [1:0] ACT_PACKET  = 2'd1;
    localparam logic [1:0] ACT_DROP    = 2'd2;
    localparam logic [1:0] ACT_REFUSED = 2'd3;

    // event codes
    localparam logic [2:0] EV_IDLE   = 3'd0;
    localparam logic [2:0] EV_LOST   = 3'd1;
    localparam logic [2:0] EV_BACK   = 3'd2;
    localparam logic [2:0] EV_RETRY  = 3'd3;
    localparam logic [2:0] EV_GAVEUP = 3'd4;

    // loss causes
    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_DROP    = 3'd1;
    localparam logic [2:0] CAUSE_STALL   = 3'd2;
    localparam logic [2:0] CAUSE_SILENCE = 3'd3;
    localparam logic [2:0] CAUSE_SOCKET  = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_STALL_LIMIT   = 2'd0;
    localparam logic [1:0] REG_SILENCE_LIMIT = 2'd1;
    localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd2;
    localparam logic [1:0] REG_RETRY_SPACING = 2'd3;

    localparam logic [LIMIT_BITS-1:0] STALL_LIMIT_RST   = 32'd5000;
    localparam logic [LIMIT_BITS-1:0] SILENCE_LIMIT_RST = 32'd15000;
    localparam logic [COUNT_BITS-1:0] ATTEMPT_LIMIT_RST = 8'd5;
    localparam logic [LIMIT_BITS-1:0] RETRY_SPACING_RST = 32'd5000;

    typedef struct packed {
        logic [1:0]            action;
        logic [TIME_BITS-1:0]  now_ms;
        logic [LIMIT_BITS-1:0] frame_delta_ms;
        logic                  drop_req;
        logic                  in_game;
        logic                  sock_closed;
        logic                  login_active;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] loss_cause;
        logic       is_lost;
        logic       has_given_up;
    } out_item_t;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] stall_limit_ms;
        logic [LIMIT_BITS-1:0] silence_limit_ms;
        logic [COUNT_BITS-1:0] attempt_limit;
        logic [LIMIT_BITS-1:0] retry_spacing_ms;
    } cfg_t;

    typedef struct packed {
        logic                  link_down;
        logic [COUNT_BITS-1:0] attempts_made;
        logic                  retry_failed;
        logic [TIME_BITS-1:0]  next_retry_ms;
        logic [TIME_BITS-1:0]  last_heard_ms;
    } wd_state_t;

endpackage

`default_nettype wire

### hdl/llwr_eval.sv
// Next-state and result logic for one watchdog item.
`timescale 1ns / 1ps
`default_nettype none

module llwr_eval
    import llwr_pkg::*;
(
    input  wire in_item_t  item,
    input  wire cfg_t      cfg,
    input  wire wd_state_t cur,
    output wd_state_t      nxt,
    output out_item_t      res
);

    localparam int EXT_BITS = TIME_BITS - LIMIT_BITS;

    logic                 heard;
    logic                 stalled;
    logic                 silent;
    logic [TIME_BITS-1:0] since_heard;
    logic [TIME_BITS:0]   retry_sum;
    logic [TIME_BITS-1:0] retry_at;
    logic [2:0]           cause;

    assign heard       = (cur.last_heard_ms != '0);
    assign stalled     = (item.frame_delta_ms >= cfg.stall_limit_ms);
    assign since_heard = item.now_ms - cur.last_heard_ms;
    assign silent      = item.in_game && (item.now_ms > cur.last_heard_ms)
                         && (since_heard >= {{EXT_BITS{1'b0}}, cfg.silence_limit_ms});
    assign retry_sum   = {1'b0, item.now_ms}
                         + {{(EXT_BITS + 1){1'b0}}, cfg.retry_spacing_ms};
    // saturate at all ones
    assign retry_at    = retry_sum[TIME_BITS] ? {TIME_BITS{1'b1}}
                                              : retry_sum[TIME_BITS-1:0];

    always_comb begin
        if (item.drop_req) begin
            cause = CAUSE_DROP;
        end else if (stalled) begin
            cause = CAUSE_STALL;
        end else if (silent) begin
            cause = CAUSE_SILENCE;
        end else if (item.sock_closed) begin
            cause = CAUSE_SOCKET;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    always_comb begin
        nxt           = cur;
        res.event_res = EV_IDLE;
        res.loss_cause = CAUSE_NONE;
        case (item.action)
            ACT_STEP: begin
                if (!cur.link_down) begin
                    if (heard && cause != CAUSE_NONE) begin
                        nxt.link_down     = 1'b1;
                        nxt.attempts_made = '0;
                        nxt.retry_failed  = 1'b0;
                        nxt.next_retry_ms = '0;
                        res.event_res     = EV_LOST;
                        res.loss_cause    = cause;
                    end
                end else if (item.in_game) begin
                    nxt.link_down     = 1'b0;
                    nxt.attempts_made = '0;
                    nxt.last_heard_ms = item.now_ms;
                    res.event_res     = EV_BACK;
                end else if (item.login_active || cur.retry_failed
                             || item.now_ms < cur.next_retry_ms) begin
                    res.event_res = EV_IDLE;
                end else if (cur.attempts_made >= cfg.attempt_limit) begin
                    nxt.retry_failed = 1'b1;
                    res.event_res    = EV_GAVEUP;
                end else begin
                    nxt.attempts_made = cur.attempts_made + 1'b1;
                    nxt.next_retry_ms = retry_at;
                    res.event_res     = EV_RETRY;
                end
            end
            ACT_PACKET: begin
                nxt.last_heard_ms = item.now_ms;
            end
            ACT_DROP: begin
                if (!cur.link_down) begin
                    nxt.link_down     = 1'b1;
                    nxt.attempts_made = '0;
                    nxt.retry_failed  = 1'b0;
                    nxt.next_retry_ms = '0;
                    res.event_res     = EV_LOST;
                end
            end
            ACT_REFUSED: begin
                nxt.retry_failed = 1'b1;
            end
            default: begin
                nxt = cur;
            end
        endcase
        res.is_lost      = nxt.link_down;
        res.has_given_up = nxt.retry_failed;
    end

endmodule

`default_nettype wire

### hdl/link_loss_watchdog_reconnect_core.sv
// Top level of the link loss watchdog: channels, register file, state and pipeline.
//
//   Port group  Dir  Handshake          Payload
//   s_*         in   s_valid / s_ready  s_data  (in_item_t)
//   m_*         out  m_valid / m_ready  m_data  (out_item_t)
//   APB         in   psel/penable/pwrite, pready tied high; paddr, pwdata, prdata
//
// One item per cycle sustained while m_ready is high; each item passes from the
// input register through the evaluate stage into the result register.
// The watchdog state is updated as an item moves into the result register.
// A stalled result holds; the input register takes items while empty or while the
// result register is free or being drained. Synchronous active-low reset.
`timescale 1ns / 1ps
`default_nettype none

module link_loss_watchdog_reconnect_core
    import llwr_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,

    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire in_item_t        s_data,

    output logic                 m_valid,
    input  wire                  m_ready,
    output out_item_t            m_data,

    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [APB_ADDR_W-1:0] paddr,
    input  wire [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                 pready
);

    cfg_t      cfg_reg;
    wd_state_t state_reg;
    wd_state_t state_next;
    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t res_reg;
    out_item_t res_next;
    logic      res_valid_reg;
    logic      advance;
    logic      cfg_write;
    logic [1:0] reg_index;

    // ---------------- register file ----------------
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stall_limit_ms   <= STALL_LIMIT_RST;
            cfg_reg.silence_limit_ms <= SILENCE_LIMIT_RST;
            cfg_reg.attempt_limit    <= ATTEMPT_LIMIT_RST;
            cfg_reg.retry_spacing_ms <= RETRY_SPACING_RST;
        end else if (cfg_write) begin
            case (reg_index)
                REG_STALL_LIMIT:   cfg_reg.stall_limit_ms   <= pwdata;
                REG_SILENCE_LIMIT: cfg_reg.silence_limit_ms <= pwdata;
                REG_ATTEMPT_LIMIT: cfg_reg.attempt_limit    <= pwdata[COUNT_BITS-1:0];
                REG_RETRY_SPACING: cfg_reg.retry_spacing_ms <= pwdata;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_STALL_LIMIT:   prdata = cfg_reg.stall_limit_ms;
            REG_SILENCE_LIMIT: prdata = cfg_reg.silence_limit_ms;
            REG_ATTEMPT_LIMIT: prdata = {{(APB_DATA_W - COUNT_BITS){1'b0}},
                                         cfg_reg.attempt_limit};
            REG_RETRY_SPACING: prdata = cfg_reg.retry_spacing_ms;
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    assign advance = item_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;
    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    llwr_eval u_eval (
        .item (item_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // ---------------- assertions ----------------
    a_lost_sets_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_res == EV_LOST) |-> m_data.is_lost)
        else $error("loss reported while link not marked down");

    a_back_clears_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_res == EV_BACK) |-> !m_data.is_lost)
        else $error("re-establish reported while link still down");

    a_cause_only_on_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.loss_cause != CAUSE_NONE) |-> m_data.event_res == EV_LOST)
        else $error("loss cause without loss event");

    a_gaveup_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_res == EV_GAVEUP)
            |-> (m_data.has_given_up && m_data.is_lost))
        else $error("give-up reported without failed state");

    a_state_moves_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("watchdog state changed without an item");

endmodule

`default_nettype wire
